// ----- rtl/hrhp_pkg.sv -----
// Package for the HTTP reply header parser: phase and tag codes, the queue
// entry type and the header name table with its lookup functions.
// No dependencies; every rtl file of the block refers to it by scoped names.
package hrhp_pkg;

    // Parse phase of the back end
    typedef enum logic [3:0] {
        PH_STATUS = 4'd0,
        PH_HEADER = 4'd1,
        PH_DATE   = 4'd2,
        PH_SERVER = 4'd3,
        PH_LENGTH = 4'd4,
        PH_CONN   = 4'd5,
        PH_TYPE   = 4'd6,
        PH_BODY   = 4'd7
    } t_phase;

    // Field tags on the result channel
    localparam logic [3:0] TAG_NONE     = 4'd0;
    localparam logic [3:0] TAG_PROTOCOL = 4'd1;
    localparam logic [3:0] TAG_STATUS   = 4'd2;
    localparam logic [3:0] TAG_DATE     = 4'd3;
    localparam logic [3:0] TAG_SERVER   = 4'd4;
    localparam logic [3:0] TAG_CONN     = 4'd5;
    localparam logic [3:0] TAG_TYPE     = 4'd6;
    localparam logic [3:0] TAG_BODY     = 4'd7;
    localparam logic [3:0] TAG_LENGTH   = 4'd8;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Classified request handed from front end to back end
    typedef struct packed {
        logic [7:0] byte_val;
        logic       restart;
        logic       is_cr;
        logic       is_space;
        logic       is_colon;
        logic       is_digit;
        logic       two_back_cr;
    } t_item;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Header name table
    localparam int NAME_COUNT = 7;
    localparam int NAME_MAX   = 18;
    localparam logic [4:0] POS_MAX = 5'd31;

    localparam logic [8*NAME_MAX-1:0] NAME_TEXT [NAME_COUNT] = '{
        "Date", "Request timestamp", "Server", "server",
        "Content-Length", "Connection", "Content-Type"
    };
    localparam logic [4:0] NAME_LEN [NAME_COUNT] = '{
        5'd4, 5'd17, 5'd6, 5'd6, 5'd14, 5'd10, 5'd12
    };
    localparam t_phase NAME_PHASE [NAME_COUNT] = '{
        PH_DATE, PH_DATE, PH_SERVER, PH_SERVER, PH_LENGTH, PH_CONN, PH_TYPE
    };

    // Character at position pos of name k; zero past its end
    function automatic logic [7:0] name_char(input int k, input logic [4:0] pos);
        logic [7:0] ch;
        int         off;
        ch  = 8'd0;
        off = 0;
        if (pos < NAME_LEN[k]) begin
            off = (int'(NAME_LEN[k]) - 1 - int'(pos)) * 8;
            ch  = NAME_TEXT[k][off +: 8];
        end
        return ch;
    endfunction

endpackage

// ----- rtl/http_reply_header_parser.sv -----
// HTTP reply header parser, top level: front end, request queue, back end.
// Depends on hrhp_pkg, hrhp_front, hrhp_queue and hrhp_back.
//
// Feed an HTTP reply one byte per request on the input channel; raise
// i_new_message with the first byte of each reply to restart parsing at the
// status line. Every byte comes back once, in order, on the output channel
// with a field tag (protocol, status text, date, server, connection, content
// type, body, length digits, or none for separators and skipped bytes). On
// the CR that closes a well-formed Content-Length line o_length_valid pulses
// and o_content_length carries the new value (saturated, low 32 bits). A
// non-digit in that value makes the closing CR set o_format_error and halt
// tagging until the next new message or reset. Throughput is one byte per
// clock while the receiver takes every result; the limit is the back end's
// per-byte state update (header name match and the decimal multiply-add of
// the length accumulator). The front end classifies each accepted byte into
// a two-entry queue, the back end parses it into the output register. The
// queue and output register absorb short stalls on either side.
module http_reply_header_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_new_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_out,
    output logic [3:0]  o_field_tag,
    output logic        o_length_valid,
    output logic [31:0] o_content_length,
    output logic        o_format_error
);

    hrhp_pkg::t_item push_item;
    hrhp_pkg::t_item head_item;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_valid;

    // Classify the accepted request and hold the raw byte history
    hrhp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_byte_in    (i_byte_in),
        .i_new_message(i_new_message),
        .i_queue_full (queue_full),
        .o_in_ready   (o_in_ready),
        .o_push       (push),
        .o_item       (push_item)
    );

    // Decouple acceptance from parsing
    hrhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (head_item)
    );

    // Advance the parse state and register the tagged result
    hrhp_back #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (queue_valid),
        .i_item          (head_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_out      (o_byte_out),
        .o_field_tag     (o_field_tag),
        .o_length_valid  (o_length_valid),
        .o_content_length(o_content_length),
        .o_format_error  (o_format_error)
    );

    // A halted parser tags nothing
    a_halt_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_format_error) |-> (o_field_tag == hrhp_pkg::TAG_NONE))
        else $error("tagged byte while halted");

    // A completed length line never coincides with the error
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_valid) |->
            (!o_format_error && (o_field_tag == hrhp_pkg::TAG_NONE)))
        else $error("length valid with error or tag");

    // Tags stay within the defined codes
    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_field_tag <= hrhp_pkg::TAG_LENGTH))
        else $error("undefined field tag");

    // The queue never pops when empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> queue_valid)
        else $error("pop from empty queue");

endmodule

// ----- rtl/hrhp_front.sv -----
// Front end of the HTTP reply header parser: accepts raw bytes, keeps the
// raw byte history and classifies each byte into a queue entry.
// Depends on hrhp_pkg.
module hrhp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_byte_in,
    input  logic                i_new_message,
    input  logic                i_queue_full,
    output logic                o_in_ready,
    output logic                o_push,
    output hrhp_pkg::t_item     o_item
);

    logic [15:0] r_hist;
    logic [15:0] n_hist;
    logic [7:0]  two_back;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // A restart clears the history before this byte enters it
    assign two_back = i_new_message ? 8'd0 : r_hist[15:8];
    assign n_hist   = {(i_new_message ? 8'd0 : r_hist[7:0]), i_byte_in};

    always_comb begin
        o_item.byte_val    = i_byte_in;
        o_item.restart     = i_new_message;
        o_item.is_cr       = (i_byte_in == hrhp_pkg::CH_CR);
        o_item.is_space    = (i_byte_in == hrhp_pkg::CH_SPACE);
        o_item.is_colon    = (i_byte_in == hrhp_pkg::CH_COLON);
        o_item.is_digit    = (i_byte_in >= hrhp_pkg::CH_ZERO) &&
                             (i_byte_in <= hrhp_pkg::CH_NINE);
        o_item.two_back_cr = (two_back == hrhp_pkg::CH_CR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= 16'd0;
        end else if (o_push) begin
            r_hist <= n_hist;
        end
    end

endmodule

// ----- rtl/hrhp_queue.sv -----
// Two-entry queue of classified requests between front and back end.
// Depends on hrhp_pkg.
module hrhp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hrhp_pkg::t_item     i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output hrhp_pkg::t_item     o_item
);

    localparam int PW = hrhp_pkg::QUEUE_PTR_W;
    localparam int CW = hrhp_pkg::QUEUE_CNT_W;
    localparam logic [PW-1:0] LAST = PW'(hrhp_pkg::QUEUE_DEPTH - 1);

    hrhp_pkg::t_item r_mem [hrhp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(hrhp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/hrhp_back.sv -----
// Back end of the HTTP reply header parser: parse state machine, header name
// matcher, decimal length accumulator and the registered result slot.
// Depends on hrhp_pkg.
module hrhp_back #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  hrhp_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_byte_out,
    output logic [3:0]          o_field_tag,
    output logic                o_length_valid,
    output logic [31:0]         o_content_length,
    output logic                o_format_error
);

    localparam int NC = hrhp_pkg::NAME_COUNT;

    hrhp_pkg::t_phase       r_phase, c_phase, n_phase;
    logic                   r_after_space, c_after_space, n_after_space;
    logic                   r_skip, c_skip, n_skip;
    logic [4:0]             r_pos, c_pos, n_pos;
    logic [NC-1:0]          r_cand, c_cand, n_cand;
    logic [LENGTH_BITS-1:0] r_accum, c_accum, n_accum;
    logic                   r_bad, c_bad, n_bad;
    logic                   r_halted, c_halted, n_halted;
    logic [LENGTH_BITS-1:0] r_len, c_len, n_len;

    logic                   r_out_valid;
    logic [7:0]             r_byte;
    logic [3:0]             r_tag, n_tag;
    logic                   r_lvalid, n_lvalid;

    logic [LENGTH_BITS+3:0] acc_next;
    logic [LENGTH_BITS+31:0] len_ext;
    hrhp_pkg::t_phase       hit_phase;

    assign o_pop = i_item_valid && (!r_out_valid || i_out_ready);

    // Ten times the accumulator plus the digit; saturate on any carry out
    assign acc_next = ({4'd0, c_accum} << 3) + ({4'd0, c_accum} << 1) +
                      (LENGTH_BITS + 4)'(i_item.byte_val[3:0]);

    always_comb begin
        hit_phase = hrhp_pkg::PH_HEADER;
        for (int k = NC - 1; k >= 0; k--) begin
            if (c_cand[k] && (c_pos == hrhp_pkg::NAME_LEN[k])) begin
                hit_phase = hrhp_pkg::NAME_PHASE[k];
            end
        end
    end

    always_comb begin
        // Restart presents the reset state to this byte
        c_phase       = i_item.restart ? hrhp_pkg::PH_STATUS : r_phase;
        c_after_space = i_item.restart ? 1'b0 : r_after_space;
        c_skip        = i_item.restart ? 1'b0 : r_skip;
        c_pos         = i_item.restart ? 5'd0 : r_pos;
        c_cand        = i_item.restart ? '1 : r_cand;
        c_accum       = i_item.restart ? '0 : r_accum;
        c_bad         = i_item.restart ? 1'b0 : r_bad;
        c_halted      = i_item.restart ? 1'b0 : r_halted;
        c_len         = i_item.restart ? '0 : r_len;

        n_phase       = c_phase;
        n_after_space = c_after_space;
        n_skip        = c_skip;
        n_pos         = c_pos;
        n_cand        = c_cand;
        n_accum       = c_accum;
        n_bad         = c_bad;
        n_halted      = c_halted;
        n_len         = c_len;
        n_tag         = hrhp_pkg::TAG_NONE;
        n_lvalid      = 1'b0;

        if (c_halted) begin
            n_halted = 1'b1;
        end else if (c_skip) begin
            n_skip = 1'b0;
        end else begin
            case (c_phase)
                hrhp_pkg::PH_STATUS: begin
                    if (!c_after_space) begin
                        if (i_item.is_space) begin
                            n_after_space = 1'b1;
                        end else begin
                            n_tag = hrhp_pkg::TAG_PROTOCOL;
                        end
                    end else if (i_item.is_cr) begin
                        n_phase = hrhp_pkg::PH_HEADER;
                        n_skip  = 1'b1;
                        n_pos   = 5'd0;
                        n_cand  = '1;
                    end else begin
                        n_tag = hrhp_pkg::TAG_STATUS;
                    end
                end
                hrhp_pkg::PH_HEADER: begin
                    if (i_item.is_colon) begin
                        n_skip  = 1'b1;
                        n_phase = hit_phase;
                        n_pos   = 5'd0;
                        n_cand  = '1;
                    end else if (i_item.is_cr) begin
                        if (i_item.two_back_cr) begin
                            n_phase = hrhp_pkg::PH_BODY;
                        end
                        n_skip = 1'b1;
                        n_pos  = 5'd0;
                        n_cand = '1;
                    end else begin
                        for (int k = 0; k < NC; k++) begin
                            if ((c_pos >= hrhp_pkg::NAME_LEN[k]) ||
                                (hrhp_pkg::name_char(k, c_pos) != i_item.byte_val)) begin
                                n_cand[k] = 1'b0;
                            end
                        end
                        if (c_pos < hrhp_pkg::POS_MAX) begin
                            n_pos = c_pos + 5'd1;
                        end
                    end
                end
                hrhp_pkg::PH_LENGTH: begin
                    if (i_item.is_cr) begin
                        n_skip  = 1'b1;
                        n_phase = hrhp_pkg::PH_HEADER;
                        n_pos   = 5'd0;
                        n_cand  = '1;
                        if (c_bad) begin
                            n_halted = 1'b1;
                        end else begin
                            n_len    = c_accum;
                            n_lvalid = 1'b1;
                        end
                        n_accum = '0;
                        n_bad   = 1'b0;
                    end else begin
                        n_tag = hrhp_pkg::TAG_LENGTH;
                        if (i_item.is_digit) begin
                            if (acc_next[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                                n_accum = '1;
                            end else begin
                                n_accum = acc_next[LENGTH_BITS-1:0];
                            end
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                end
                hrhp_pkg::PH_DATE, hrhp_pkg::PH_SERVER,
                hrhp_pkg::PH_CONN, hrhp_pkg::PH_TYPE: begin
                    if (i_item.is_cr) begin
                        n_skip  = 1'b1;
                        n_phase = hrhp_pkg::PH_HEADER;
                        n_pos   = 5'd0;
                        n_cand  = '1;
                    end else if (c_phase == hrhp_pkg::PH_DATE) begin
                        n_tag = hrhp_pkg::TAG_DATE;
                    end else if (c_phase == hrhp_pkg::PH_SERVER) begin
                        n_tag = hrhp_pkg::TAG_SERVER;
                    end else if (c_phase == hrhp_pkg::PH_CONN) begin
                        n_tag = hrhp_pkg::TAG_CONN;
                    end else begin
                        n_tag = hrhp_pkg::TAG_TYPE;
                    end
                end
                hrhp_pkg::PH_BODY: begin
                    n_tag = hrhp_pkg::TAG_BODY;
                end
                default: begin
                    n_phase = hrhp_pkg::PH_STATUS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hrhp_pkg::PH_STATUS;
            r_after_space <= 1'b0;
            r_skip        <= 1'b0;
            r_pos         <= 5'd0;
            r_cand        <= '1;
            r_accum       <= '0;
            r_bad         <= 1'b0;
            r_halted      <= 1'b0;
            r_len         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase       <= n_phase;
                r_after_space <= n_after_space;
                r_skip        <= n_skip;
                r_pos         <= n_pos;
                r_cand        <= n_cand;
                r_accum       <= n_accum;
                r_bad         <= n_bad;
                r_halted      <= n_halted;
                r_len         <= n_len;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte   <= i_item.byte_val;
            r_tag    <= n_tag;
            r_lvalid <= n_lvalid;
        end
    end

    assign len_ext          = {32'd0, r_len};
    assign o_out_valid      = r_out_valid;
    assign o_byte_out       = r_byte;
    assign o_field_tag      = r_tag;
    assign o_length_valid   = r_lvalid;
    assign o_content_length = len_ext[31:0];
    assign o_format_error   = r_halted;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for http_reply_header_parser: byte stream in, tagged bytes out.
// Depends on hrhp_pkg and the block's rtl; holds its own byte tagger for prediction.
module tb_top;

    localparam int HDR_COUNT      = 7;
    localparam int HDR_LENGTH_IDX = 4;    // index of Content-Length in the name table
    localparam int HDR_LONG       = 8;    // extra kinds used by the random replies
    localparam int HDR_PREFIX     = 9;
    localparam int HOLD_CYCLES    = 100;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_ALTERNATE
    } t_rx_mode;

    // One tagged byte as it leaves the block
    typedef struct packed {
        logic [7:0]  byte_val;
        logic [3:0]  tag;
        logic        len_valid;
        logic [31:0] len_value;
        logic        fmt_err;
    } t_reply_tag;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_in = 8'd0;
    logic        i_new_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_byte_out;
    logic [3:0]  o_field_tag;
    logic        o_length_valid;
    logic [31:0] o_content_length;
    logic        o_format_error;

    http_reply_header_parser u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_in        (i_byte_in),
        .i_new_message    (i_new_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_out       (o_byte_out),
        .o_field_tag      (o_field_tag),
        .o_length_valid   (o_length_valid),
        .o_content_length (o_content_length),
        .o_format_error   (o_format_error)
    );

    always #5 i_clk = ~i_clk;

    // Header names the tagger knows, and the value phase each one selects
    string  hdr_names [HDR_COUNT] = '{
        "Date", "Request timestamp", "Server", "server",
        "Content-Length", "Connection", "Content-Type"
    };
    hrhp_pkg::t_phase hdr_phase [HDR_COUNT] = '{
        hrhp_pkg::PH_DATE, hrhp_pkg::PH_DATE, hrhp_pkg::PH_SERVER, hrhp_pkg::PH_SERVER,
        hrhp_pkg::PH_LENGTH, hrhp_pkg::PH_CONN, hrhp_pkg::PH_TYPE
    };

    // Tagger state, mirrors the block after every accepted request
    hrhp_pkg::t_phase pred_phase;
    logic        seen_space;
    logic        skip_byte;
    logic [4:0]  name_idx;
    logic [6:0]  name_live;
    logic [31:0] len_acc;
    logic        len_err;
    logic [15:0] byte_hist;
    logic        parse_stopped;
    logic [31:0] len_latest;

    t_reply_tag  pending_tags [$];
    t_reply_tag  seen_reply;
    t_reply_tag  due_reply;
    int          errors = 0;
    int          items_sent = 0;

    // Sender burst control
    int          burst_left = 0;
    bit          sender_gaps = 1'b1;

    // Receiver stall control; the test side bumps hold_asks to request a long hold
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    t_rx_mode    rx_mode = RX_ALWAYS;

    function automatic void clear_parse_state();
        pred_phase    = hrhp_pkg::PH_STATUS;
        seen_space    = 1'b0;
        skip_byte     = 1'b0;
        name_idx      = 5'd0;
        name_live     = '1;
        len_acc       = 32'd0;
        len_err       = 1'b0;
        byte_hist     = 16'd0;
        parse_stopped = 1'b0;
        len_latest    = 32'd0;
    endfunction

    // Tag one byte and advance the tagger state
    function automatic t_reply_tag tag_reply_byte(input logic [7:0] b, input logic nm);
        t_reply_tag  r;
        logic [7:0]  two_back;
        logic [3:0]  tag;
        logic        valid;
        logic [63:0] acc;
        logic [63:0] digit;
        hrhp_pkg::t_phase next;
        tag   = hrhp_pkg::TAG_NONE;
        valid = 1'b0;
        if (nm)
            clear_parse_state();
        two_back = byte_hist[15:8];

        if (parse_stopped) begin
            // halted: only the byte history moves
        end else if (skip_byte) begin
            skip_byte = 1'b0;
        end else begin
            case (pred_phase)
                hrhp_pkg::PH_STATUS: begin
                    if (!seen_space) begin
                        if (b == hrhp_pkg::CH_SPACE)
                            seen_space = 1'b1;
                        else
                            tag = hrhp_pkg::TAG_PROTOCOL;
                    end else if (b == hrhp_pkg::CH_CR) begin
                        pred_phase = hrhp_pkg::PH_HEADER;
                        skip_byte  = 1'b1;
                        name_idx   = 5'd0;
                        name_live  = '1;
                    end else begin
                        tag = hrhp_pkg::TAG_STATUS;
                    end
                end
                hrhp_pkg::PH_HEADER: begin
                    if (b == hrhp_pkg::CH_COLON) begin
                        // walk down so the first table entry wins
                        next = hrhp_pkg::PH_HEADER;
                        for (int k = HDR_COUNT - 1; k >= 0; k--)
                            if (name_live[k] && name_idx == hdr_names[k].len())
                                next = hdr_phase[k];
                        pred_phase = next;
                        skip_byte  = 1'b1;
                        name_idx   = 5'd0;
                        name_live  = '1;
                    end else if (b == hrhp_pkg::CH_CR) begin
                        if (two_back == hrhp_pkg::CH_CR)
                            pred_phase = hrhp_pkg::PH_BODY;
                        skip_byte = 1'b1;
                        name_idx  = 5'd0;
                        name_live = '1;
                    end else begin
                        for (int k = 0; k < HDR_COUNT; k++)
                            if (name_idx >= hdr_names[k].len() ||
                                hdr_names[k][name_idx] != b)
                                name_live[k] = 1'b0;
                        if (name_idx < hrhp_pkg::POS_MAX)
                            name_idx = name_idx + 5'd1;
                    end
                end
                hrhp_pkg::PH_LENGTH: begin
                    if (b == hrhp_pkg::CH_CR) begin
                        skip_byte  = 1'b1;
                        pred_phase = hrhp_pkg::PH_HEADER;
                        name_idx   = 5'd0;
                        name_live  = '1;
                        if (len_err) begin
                            parse_stopped = 1'b1;
                        end else begin
                            len_latest = len_acc;
                            valid      = 1'b1;
                        end
                        len_acc = 32'd0;
                        len_err = 1'b0;
                    end else begin
                        tag = hrhp_pkg::TAG_LENGTH;
                        if (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) begin
                            digit = 64'(b - hrhp_pkg::CH_ZERO);
                            acc   = 64'(len_acc);
                            if (acc > (64'hFFFF_FFFF - digit) / 10)
                                len_acc = '1;
                            else
                                len_acc = 32'(acc * 10 + digit);
                        end else begin
                            len_err = 1'b1;
                        end
                    end
                end
                hrhp_pkg::PH_DATE, hrhp_pkg::PH_SERVER,
                hrhp_pkg::PH_CONN, hrhp_pkg::PH_TYPE: begin
                    if (b == hrhp_pkg::CH_CR) begin
                        skip_byte  = 1'b1;
                        pred_phase = hrhp_pkg::PH_HEADER;
                        name_idx   = 5'd0;
                        name_live  = '1;
                    end else begin
                        case (pred_phase)
                            hrhp_pkg::PH_DATE:   tag = hrhp_pkg::TAG_DATE;
                            hrhp_pkg::PH_SERVER: tag = hrhp_pkg::TAG_SERVER;
                            hrhp_pkg::PH_CONN:   tag = hrhp_pkg::TAG_CONN;
                            default:             tag = hrhp_pkg::TAG_TYPE;
                        endcase
                    end
                end
                hrhp_pkg::PH_BODY: tag = hrhp_pkg::TAG_BODY;
                default: pred_phase = hrhp_pkg::PH_STATUS;
            endcase
        end

        byte_hist   = {byte_hist[7:0], b};
        r.byte_val  = b;
        r.tag       = tag;
        r.len_valid = valid;
        r.len_value = len_latest;
        r.fmt_err   = parse_stopped;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte_but(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == avoid);
        return b;
    endfunction

    // Offer one request; return right after the edge that accepted it
    task automatic send_byte(input logic [7:0] b, input logic nm);
        int gap;
        if (burst_left == 0) begin
            gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_byte_in     <= b;
        i_new_message <= nm;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_tags.push_back(tag_reply_byte(b, nm));
        items_sent++;
    endtask

    // Send the text followed by CR LF
    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
        send_byte(hrhp_pkg::CH_CR, 1'b0);
        send_byte(8'd10, 1'b0);
    endtask

    // Drop valid and hold until every tagged byte is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (pending_tags.size() != 0);
    endtask

    // Status line at the byte extremes, then an empty header block right after reset
    task automatic test_status_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(hrhp_pkg::CH_SPACE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(hrhp_pkg::CH_CR, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(hrhp_pkg::CH_CR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Every known header name once, then the body
    task automatic test_known_headers();
        send_byte("H", 1'b1);
        send_line(" 2");
        send_line("Date: d");
        send_line("Request timestamp: t");
        send_line("Server: s");
        send_line("server: s");
        send_line("Content-Length: 7");
        send_line("Connection: c");
        send_line("Content-Type: y");
        send_line("");
        send_byte("z", 1'b0);
    endtask

    // Saturation, empty value, unknown and long names, then a bad value that halts
    task automatic test_length_cases();
        send_byte("H", 1'b1);
        send_line(" ");
        send_line("Content-Length: 99999999999");
        send_line("Content-Length: ");
        send_line("X: a");
        send_line("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa: v");
        send_line("Content-Length: 1x");
        send_byte(":", 1'b0);
        send_byte("q", 1'b0);
        send_byte("H", 1'b1);
        send_byte(hrhp_pkg::CH_SPACE, 1'b0);
    endtask

    // Hold the receiver off while the sender keeps pushing, then drain fully
    task automatic test_output_stall();
        hold_asks++;
        sender_gaps = 1'b0;
        send_byte("H", 1'b1);
        send_line(" 200");
        send_line("Server: abc");
        send_line("");
        send_byte("b", 1'b0);
        send_byte("o", 1'b0);
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    // One reply with random content; some lines or endings are broken on purpose
    task automatic send_random_reply();
        int n_hdr;
        int kind;
        int len;
        int bad_pos;
        for (int i = 0; i < $urandom_range(1, 8); i++)
            send_byte(rand_byte_but(hrhp_pkg::CH_SPACE), i == 0);
        send_byte(hrhp_pkg::CH_SPACE, 1'b0);
        for (int i = 0; i < $urandom_range(0, 10); i++)
            send_byte(rand_byte_but(hrhp_pkg::CH_CR), 1'b0);
        send_byte(hrhp_pkg::CH_CR, 1'b0);
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd10, 1'b0);

        n_hdr = $urandom_range(0, 5);
        for (int h = 0; h < n_hdr; h++) begin
            kind = $urandom_range(0, HDR_PREFIX);
            if (kind < HDR_COUNT) begin
                for (int i = 0; i < hdr_names[kind].len(); i++)
                    send_byte(hdr_names[kind][i], 1'b0);
            end else if (kind == HDR_PREFIX) begin
                len = $urandom_range(0, 13);
                for (int i = 0; i < len; i++)
                    send_byte(hdr_names[HDR_LENGTH_IDX][i], 1'b0);
            end else begin
                len = (kind == HDR_LONG) ? $urandom_range(31, 40) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_byte(8'("a" + $urandom_range(0, 25)), 1'b0);
            end
            // a line with no colon just restarts the name
            if ($urandom_range(0, 9) != 0) begin
                send_byte(hrhp_pkg::CH_COLON, 1'b0);
                send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                          hrhp_pkg::CH_SPACE, 1'b0);
                if (kind == HDR_LENGTH_IDX) begin
                    len     = $urandom_range(0, 12);
                    bad_pos = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
                    for (int i = 0; i <= len; i++) begin
                        if (i == bad_pos)
                            send_byte(rand_byte_but(hrhp_pkg::CH_CR), 1'b0);
                        else if (i < len)
                            send_byte(8'(hrhp_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
                    end
                end else begin
                    for (int i = 0; i < $urandom_range(0, 8); i++)
                        send_byte(rand_byte_but(hrhp_pkg::CH_CR), 1'b0);
                end
            end
            send_byte(hrhp_pkg::CH_CR, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end

        if ($urandom_range(0, 7) != 0) begin
            send_byte(hrhp_pkg::CH_CR, 1'b0);
            send_byte(8'd10, 1'b0);
            for (int i = 0; i < $urandom_range(0, 8); i++)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // noise, now and then with a restart in the middle
            for (int i = 0; i < $urandom_range(1, 6); i++)
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    // The directed tests send about 270 bytes; top up to roughly 450 in all
    task automatic test_random_replies();
        int start;
        start = items_sent;
        while (items_sent - start < 180)
            send_random_reply();
    endtask

    // Receiver: random ready patterns, plus the long hold when asked
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (rx_mode)
                RX_ALWAYS:    i_out_ready <= 1'b1;
                RX_MOSTLY:    i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_RARELY:    i_out_ready <= ($urandom_range(0, 3) == 0);
                RX_ALTERNATE: i_out_ready <= ~i_out_ready;
                default:      i_out_ready <= 1'b1;
            endcase
        end
    end

    // Compare each accepted result against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_reply = {o_byte_out, o_field_tag, o_length_valid, o_content_length,
                          o_format_error};
            if (pending_tags.size() == 0) begin
                errors++;
                $display("%0t: unexpected result byte %h tag %0d", $time, o_byte_out,
                         o_field_tag);
            end else begin
                due_reply = pending_tags.pop_front();
                if (seen_reply !== due_reply) begin
                    errors++;
                    $display("%0t: expected byte %h tag %0d lv %b len %0d err %b", $time,
                             due_reply.byte_val, due_reply.tag, due_reply.len_valid,
                             due_reply.len_value, due_reply.fmt_err);
                    $display("%0t:   actual byte %h tag %0d lv %b len %0d err %b", $time,
                             seen_reply.byte_val, seen_reply.tag, seen_reply.len_valid,
                             seen_reply.len_value, seen_reply.fmt_err);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("[http_reply_header_parser] ERROR");
        $finish;
    end

    initial begin
        int waited;
        clear_parse_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_status_extremes();
        test_known_headers();
        test_length_cases();
        test_output_stall();
        test_random_replies();

        // Drain, then allow the two-stage pipe to settle
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_tags.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_tags.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_tags.size());
        end
        if (errors == 0)
            $display("[http_reply_header_parser] OK");
        else
            $display("[http_reply_header_parser] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hrhp_pkg.sv
rtl/hrhp_front.sv
rtl/hrhp_queue.sv
rtl/hrhp_back.sv
rtl/http_reply_header_parser.sv
bench/tb_top.sv
